[src/point_in_shape_list_tester_assert.svh]
// Assertion macros for the checker file of the shape hit tester.
// Each use stands on a line of its own and names its clock and reset.
`ifndef POINT_IN_SHAPE_LIST_TESTER_ASSERT_SVH
`define POINT_IN_SHAPE_LIST_TESTER_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define PIST_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition in one cycle implies a consequence in the next one.
`define PIST_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[src/pist_pkg.sv]
// ----------------------------------------------------------------------------
// pist_pkg
// Request codes, queue depth and the control bundle between front and back.
// ----------------------------------------------------------------------------
package pist_pkg;

  // Width of the one-based figure number on the result channel
  localparam int FIG_W = 5;

  // Entries of the command queue between front and back (power of two)
  localparam int QDEPTH = 2;

  typedef logic [1:0] op_t;

  localparam op_t OP_RECT   = 2'd0;
  localparam op_t OP_CIRCLE = 2'd1;
  localparam op_t OP_QUERY  = 2'd2;
  localparam op_t OP_CLEAR  = 2'd3;

  typedef struct packed {
    logic valid;
    op_t  op;
  } cmd_ctl_t;

endpackage

[src/pist_ram.sv]
// ----------------------------------------------------------------------------
// pist_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module pist_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[src/pist_front.sv]
// ----------------------------------------------------------------------------
// pist_front
// Accept requests, classify them and hold them in a short command queue.
// ----------------------------------------------------------------------------
module pist_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    func,
  input  logic signed [COORD_BITS-1:0]  a_value,
  input  logic signed [COORD_BITS-1:0]  b_value,
  input  logic signed [COORD_BITS-1:0]  c_value,
  input  logic signed [COORD_BITS-1:0]  d_value,
  output pist_pkg::cmd_ctl_t            cmd,
  output logic [4*COORD_BITS-1:0]       cmd_coords,
  input  logic                          cmd_pop
);

  import pist_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  op_t               q_op     [QDEPTH];
  logic [4*CW-1:0]   q_coords [QDEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    fill;
  logic              push;
  op_t               req_op;
  logic [CW-1:0]     d_eff;

  assign req_ready = (fill != (PTR_W+1)'(QDEPTH));
  assign push      = req_valid && req_ready;
  assign req_op    = op_t'(func);

  // Circles carry no second corner: drop the unused coordinate
  assign d_eff = (req_op == OP_CIRCLE) ? '0 : d_value;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (cmd_pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      fill <= fill + (PTR_W+1)'(push) - (PTR_W+1)'(cmd_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_op[wr_ptr]     <= req_op;
      q_coords[wr_ptr] <= {d_eff, c_value, b_value, a_value};
    end
  end

  assign cmd.valid  = (fill != '0);
  assign cmd.op     = q_op[rd_ptr];
  assign cmd_coords = q_coords[rd_ptr];

endmodule

[src/pist_back.sv]
// ----------------------------------------------------------------------------
// pist_back
// Shape table and query walker: one shape tested per cycle unless stalled.
// ----------------------------------------------------------------------------
module pist_back #(
  parameter int MAX_FIGURES = 16,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  pist_pkg::cmd_ctl_t            cmd,
  input  logic [4*COORD_BITS-1:0]       cmd_coords,
  output logic                          cmd_pop,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          status,
  output logic [pist_pkg::FIG_W-1:0]    figure_number,
  output logic                          last
);

  import pist_pkg::*;

  localparam int CW    = COORD_BITS;
  localparam int CNT_W = $clog2(MAX_FIGURES + 1);
  localparam int IDX_W = (MAX_FIGURES > 1) ? $clog2(MAX_FIGURES) : 1;
  localparam int ENT_W = 1 + 4 * CW;
  localparam int DW    = CW + 1;
  localparam int SQ_W  = 2 * DW;
  localparam int SUM_W = SQ_W + 1;
  localparam int RQ_W  = 2 * CW;
  localparam int FW    = (CNT_W > FIG_W) ? CNT_W : FIG_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic               state;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   walk_idx;
  logic signed [CW-1:0] qx;
  logic signed [CW-1:0] qy;

  logic               adv;
  logic               take;
  logic               is_load;
  logic               room;
  logic               walking;
  logic               shape_slot;
  logic               ram_we;
  logic               ram_re;
  logic [ENT_W-1:0]   ram_rdata;

  // ---- command intake and walk sequencer ----
  assign adv        = !res_valid || res_ready;
  assign take       = (state == ST_IDLE) && cmd.valid;
  assign cmd_pop    = take;
  assign is_load    = (cmd.op == OP_RECT) || (cmd.op == OP_CIRCLE);
  assign room       = (count < CNT_W'(MAX_FIGURES));
  assign walking    = (state == ST_WALK);
  assign shape_slot = (walk_idx < count);
  assign ram_we     = take && is_load && room;
  assign ram_re     = adv && walking && shape_slot;

  pist_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_FIGURES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IDX_W-1:0]),
    .wdata ({(cmd.op == OP_CIRCLE), cmd_coords}),
    .re    (ram_re),
    .raddr (walk_idx[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (take) begin
            case (cmd.op)
              OP_RECT, OP_CIRCLE: begin
                if (room) begin
                  count <= count + CNT_W'(1);
                end
              end
              OP_CLEAR: count <= '0;
              OP_QUERY: state <= ST_WALK;
              default: ;
            endcase
          end
        end
        ST_WALK: begin
          if (adv && !shape_slot) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (take && (cmd.op == OP_QUERY)) begin
      walk_idx <= '0;
      qx       <= cmd_coords[CW-1:0];
      qy       <= cmd_coords[2*CW-1:CW];
    end else if (ram_re) begin
      walk_idx <= walk_idx + CNT_W'(1);
    end
  end

  // ---- stage 1: table entry arrives, bounds and offsets ----
  logic                 s1_valid;
  logic                 s1_end;
  logic [IDX_W-1:0]     s1_idx;
  logic signed [CW-1:0] s1_qx;
  logic signed [CW-1:0] s1_qy;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= walking;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_end <= !shape_slot;
      s1_idx <= walk_idx[IDX_W-1:0];
      s1_qx  <= qx;
      s1_qy  <= qy;
    end
  end

  logic                 e_kind;
  logic signed [CW-1:0] c0;
  logic signed [CW-1:0] c1;
  logic signed [CW-1:0] c2;
  logic signed [CW-1:0] c3;
  logic signed [CW-1:0] x_lo;
  logic signed [CW-1:0] x_hi;
  logic signed [CW-1:0] y_lo;
  logic signed [CW-1:0] y_hi;
  logic                 rect_hit;
  logic signed [DW-1:0] dx;
  logic signed [DW-1:0] dy;

  assign e_kind = ram_rdata[ENT_W-1];
  assign c0     = ram_rdata[CW-1:0];
  assign c1     = ram_rdata[2*CW-1:CW];
  assign c2     = ram_rdata[3*CW-1:2*CW];
  assign c3     = ram_rdata[4*CW-1:3*CW];

  assign x_lo = (c0 < c2) ? c0 : c2;
  assign x_hi = (c0 < c2) ? c2 : c0;
  assign y_lo = (c1 < c3) ? c1 : c3;
  assign y_hi = (c1 < c3) ? c3 : c1;

  assign rect_hit = (x_lo <= s1_qx) && (s1_qx <= x_hi) &&
                    (y_lo <= s1_qy) && (s1_qy <= y_hi);

  assign dx = DW'(s1_qx) - DW'(c0);
  assign dy = DW'(s1_qy) - DW'(c1);

  // ---- stage 2: squares ----
  logic                 s2_valid;
  logic                 s2_end;
  logic [IDX_W-1:0]     s2_idx;
  logic                 s2_kind;
  logic                 s2_rect_hit;
  logic                 s2_rneg;
  logic signed [DW-1:0] s2_dx;
  logic signed [DW-1:0] s2_dy;
  logic signed [CW-1:0] s2_r;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (adv) begin
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_end      <= s1_end;
      s2_idx      <= s1_idx;
      s2_kind     <= e_kind;
      s2_rect_hit <= rect_hit;
      s2_rneg     <= c2[CW-1];
      s2_dx       <= dx;
      s2_dy       <= dy;
      s2_r        <= c2;
    end
  end

  logic signed [SQ_W-1:0] sq_x;
  logic signed [SQ_W-1:0] sq_y;
  logic signed [RQ_W-1:0] sq_r;

  assign sq_x = s2_dx * s2_dx;
  assign sq_y = s2_dy * s2_dy;
  assign sq_r = s2_r * s2_r;

  // ---- stage 3: distance compare and hit selection ----
  logic               s3_valid;
  logic               s3_end;
  logic [IDX_W-1:0]   s3_idx;
  logic               s3_kind;
  logic               s3_rect_hit;
  logic               s3_rneg;
  logic [SQ_W-1:0]    s3_dx2;
  logic [SQ_W-1:0]    s3_dy2;
  logic [RQ_W-1:0]    s3_r2;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (adv) begin
      s3_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s3_end      <= s2_end;
      s3_idx      <= s2_idx;
      s3_kind     <= s2_kind;
      s3_rect_hit <= s2_rect_hit;
      s3_rneg     <= s2_rneg;
      s3_dx2      <= sq_x;
      s3_dy2      <= sq_y;
      s3_r2       <= sq_r;
    end
  end

  logic [SUM_W-1:0] dist2;
  logic             circ_hit;
  logic             hit;
  logic [FW-1:0]    fig_wide;
  logic [FIG_W-1:0] s3_fig;

  assign dist2    = SUM_W'(s3_dx2) + SUM_W'(s3_dy2);
  assign circ_hit = !s3_rneg && (dist2 <= SUM_W'(s3_r2));
  assign hit      = s3_kind ? circ_hit : s3_rect_hit;
  assign fig_wide = FW'(s3_idx) + FW'(1);
  assign s3_fig   = fig_wide[FIG_W-1:0];

  // ---- pending hit: held back one hit so the final one can carry last ----
  logic             pend_valid;
  logic [FIG_W-1:0] pend_fig;
  logic             push;
  logic             push_status;
  logic [FIG_W-1:0] push_fig;
  logic             push_last;

  always_comb begin
    push        = 1'b0;
    push_status = 1'b0;
    push_fig    = pend_fig;
    push_last   = 1'b0;
    if (s3_valid) begin
      if (s3_end) begin
        push      = 1'b1;
        push_last = 1'b1;
        if (!pend_valid) begin
          push_status = 1'b1;
          push_fig    = '0;
        end
      end else if (hit && pend_valid) begin
        push = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (adv && s3_valid) begin
      if (s3_end) begin
        pend_valid <= 1'b0;
      end else if (hit) begin
        pend_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s3_valid && !s3_end && hit) begin
      pend_fig <= s3_fig;
    end
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (adv) begin
      res_valid <= push;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      status        <= push_status;
      figure_number <= push_fig;
      last          <= push_last;
    end
  end

endmodule

[src/point_in_shape_list_tester.sv]
// ----------------------------------------------------------------------------
// point_in_shape_list_tester
// Hit tester for a list of rectangles and circles in signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid/req_ready, func, a..d_value): func selects
//   load rectangle, load circle, query point or clear table. Loads append a
//   shape; a load into a full table is dropped. Loads and clears give no
//   result. A query gives one result per containing shape in load order
//   (status 0, one-based figure_number), or a single not-contained result
//   (status 1, figure_number 0); last marks the final result of a query.
//   Result channel (res_valid/res_ready, status, figure_number, last).
//   The back end takes no new command while it walks the table for a query;
//   the walker reads one table entry per cycle from the RAM while the
//   result channel is not stalled. A query's results pass through the RAM
//   read, offset, square, compare and output steps; a hit waits for the
//   next one so that the final result can carry last.
//   A two-entry command queue lets requests keep arriving during a walk.
//   Reset empties the table and the queue and drops any result in flight.
//   When the receiver stalls, the whole walk pipeline holds in place.
// ----------------------------------------------------------------------------
module point_in_shape_list_tester #(
  parameter int MAX_FIGURES = 16,
  parameter int COORD_BITS  = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          req_valid,
  output logic                          req_ready,
  input  logic [1:0]                    func,
  input  logic signed [COORD_BITS-1:0]  a_value,
  input  logic signed [COORD_BITS-1:0]  b_value,
  input  logic signed [COORD_BITS-1:0]  c_value,
  input  logic signed [COORD_BITS-1:0]  d_value,
  output logic                          res_valid,
  input  logic                          res_ready,
  output logic                          status,
  output logic [pist_pkg::FIG_W-1:0]    figure_number,
  output logic                          last
);

  import pist_pkg::*;

  // Decoded command at the head of the queue, and its coordinates
  cmd_ctl_t                  cmd;
  logic [4*COORD_BITS-1:0]   cmd_coords;
  logic                      cmd_pop;

  // Front: accept and classify requests, queue them
  pist_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .req_valid  (req_valid),
    .req_ready  (req_ready),
    .func       (func),
    .a_value    (a_value),
    .b_value    (b_value),
    .c_value    (c_value),
    .d_value    (d_value),
    .cmd        (cmd),
    .cmd_coords (cmd_coords),
    .cmd_pop    (cmd_pop)
  );

  // Back: shape table, query walk and result register
  pist_back #(
    .MAX_FIGURES (MAX_FIGURES),
    .COORD_BITS  (COORD_BITS)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .cmd_coords    (cmd_coords),
    .cmd_pop       (cmd_pop),
    .res_valid     (res_valid),
    .res_ready     (res_ready),
    .status        (status),
    .figure_number (figure_number),
    .last          (last)
  );

endmodule

[src/pist_checker.sv]
// ----------------------------------------------------------------------------
// pist_checker
// Port-level checks on the result channel of the shape hit tester.
// ----------------------------------------------------------------------------
`include "point_in_shape_list_tester_assert.svh"

module pist_checker #(
  parameter int MAX_FIGURES = 16
) (
  input logic                       clk,
  input logic                       rst,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic                       status,
  input logic [pist_pkg::FIG_W-1:0] figure_number,
  input logic                       last
);

  import pist_pkg::*;

  logic             open_query;
  logic [FIG_W-1:0] prev_fig;

  // Track whether the current query has results still to come
  always_ff @(posedge clk) begin
    if (rst) begin
      open_query <= 1'b0;
    end else if (res_valid && res_ready) begin
      open_query <= !last;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      prev_fig <= figure_number;
    end
  end

  `PIST_ASSERT_NEXT(a_res_hold, clk, rst, res_valid && !res_ready, res_valid && $stable(status) && $stable(figure_number) && $stable(last), "result changed while stalled")
  `PIST_ASSERT_NEXT(a_reset_idle, clk, 1'b0, rst, !res_valid, "result shown right after reset")
  `PIST_ASSERT(a_miss_form, clk, rst, (res_valid && status) |-> (figure_number == '0 && last), "not-contained result malformed")
  `PIST_ASSERT(a_hit_order, clk, rst, (res_valid && open_query) |-> (!status && ((MAX_FIGURES > 31) || figure_number > prev_fig)), "hits out of load order")

endmodule

bind point_in_shape_list_tester pist_checker #(
  .MAX_FIGURES (MAX_FIGURES)
) u_pist_checker (.*);
